// ===== sv/swd_pkg.sv =====
`default_nettype none
package swd_pkg;

	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC_WORD    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GROUP_LENGTH = 2'd1;

	localparam logic [31:0] SYNC_WORD_RST    = 32'hDEAD_BEEF;
	localparam logic [3:0]  GROUP_LENGTH_RST = 4'd3;

	localparam logic [2:0] SKIP_BYTES = 3'd4;
	localparam logic [1:0] PAIR_BYTES = 2'd2;

	typedef struct packed {
		logic [15:0] element;
		logic        end_of_line;
	} swd_result_t;

endpackage
`default_nettype wire

// ===== sv/swd_core.sv =====
`default_nettype none
module swd_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire logic [7:0]         rx_byte,
	input  wire logic [31:0]        sync_word,
	input  wire logic [3:0]         group_length,
	output logic                    emit,
	output swd_pkg::swd_result_t    result
);
	import swd_pkg::*;

	logic [31:0] window_q;
	logic        synced_q;
	logic [2:0]  align_q;
	logic [1:0]  pair_q;
	logic [3:0]  group_q;

	logic [31:0] window_n;
	logic        hit;
	logic        synced_n;
	logic [2:0]  align_b, align_n;
	logic [1:0]  pair_b, pair_n;
	logic [3:0]  group_b, group_n;
	logic        last;

	always_comb begin
		window_n = {window_q[23:0], rx_byte};
		hit      = (window_n == sync_word);
		synced_n = synced_q | hit;
		align_b  = hit ? 3'd0 : align_q;
		pair_b   = hit ? PAIR_BYTES : pair_q;
		group_b  = hit ? 4'd1 : group_q;
		last     = !(group_b < group_length);

		align_n = align_b;
		pair_n  = pair_b;
		group_n = group_b;
		emit    = 1'b0;
		if (synced_n) begin
			if (align_b != SKIP_BYTES) begin
				align_n = align_b + 3'd1;
			end else if (pair_b != PAIR_BYTES) begin
				pair_n = pair_b + 2'd1;
			end else begin
				emit    = 1'b1;
				pair_n  = 2'd1;
				group_n = last ? 4'd1 : group_b + 4'd1;
			end
		end

		result.element     = window_n[31:16];
		result.end_of_line = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			synced_q <= 1'b0;
			align_q  <= '0;
			pair_q   <= '0;
			group_q  <= '0;
		end else if (step) begin
			window_q <= window_n;
			synced_q <= synced_n;
			align_q  <= align_n;
			pair_q   <= pair_n;
			group_q  <= group_n;
		end
	end

	a_align_bound: assert property (@(posedge clk) disable iff (!arst_n)
		align_q <= SKIP_BYTES)
		else $error("align count past skip length");

	a_pair_set: assert property (@(posedge clk) disable iff (!arst_n)
		synced_q |-> (pair_q == 2'd1 || pair_q == PAIR_BYTES))
		else $error("pair phase invalid after sync");

	a_emit_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(step && emit && !hit) |-> (synced_q && align_q == SKIP_BYTES
			&& pair_q == PAIR_BYTES))
		else $error("element emitted out of alignment");

	a_no_emit_on_sync: assert property (@(posedge clk) disable iff (!arst_n)
		hit |-> !emit)
		else $error("element emitted on sync byte");

endmodule
`default_nettype wire

// ===== sv/sync_word_deframer.sv =====
`default_nettype none
// channel  | direction | handshake                  | payload
// s_axis   | in        | s_axis_tvalid/s_axis_tready | tdata[7:0] rx_byte
// m_axis   | out       | m_axis_tvalid/m_axis_tready | tdata[15:0] element, tlast end_of_line
// cfg      | in        | cfg_valid/cfg_ready         | cfg_index, cfg_data
//
// One byte per cycle sustained while m_axis is not stalled; a byte's element reaches
// m_axis via the input register, single-pass state update, then one output register.
// Stall on m_axis holds the output register and the input register; s_axis
// stays ready while the input register is empty or moving.
// arst_n clears all control state; registers reset to 0xDEADBEEF and 3.
module sync_word_deframer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [15:0]                        m_axis_tdata,  // [15:0] element
	output logic                               m_axis_tlast,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [swd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                   cfg_data
);
	import swd_pkg::*;

	logic        byte_valid_s1;
	logic [7:0]  byte_s1;
	logic        out_valid_q;
	swd_result_t out_q;
	logic [31:0] sync_word_q;
	logic [3:0]  group_length_q;

	logic        advance;
	logic        step;
	logic        emit;
	swd_result_t result;

	assign advance       = !out_valid_q || m_axis_tready;
	assign step          = byte_valid_s1 && advance;
	assign s_axis_tready = !byte_valid_s1 || advance;
	assign cfg_ready     = 1'b1;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q.element;
	assign m_axis_tlast  = out_q.end_of_line;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_word_q    <= SYNC_WORD_RST;
			group_length_q <= GROUP_LENGTH_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SYNC_WORD:    sync_word_q    <= cfg_data;
				REG_GROUP_LENGTH: group_length_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			byte_valid_s1 <= 1'b1;
		end else if (advance) begin
			byte_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			out_q <= result;
		end
	end

	swd_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.rx_byte      (byte_s1),
		.sync_word    (sync_word_q),
		.group_length (group_length_q),
		.emit         (emit),
		.result       (result)
	);

	a_out_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(byte_valid_s1))
		else $error("output appeared without a byte in the input register");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_valid_s1 && !advance) |=> (byte_valid_s1 && $stable(byte_s1)))
		else $error("input register lost a byte while stalled");

endmodule
`default_nettype wire
